[sv/xed_pkg.sv]
// ----------------------------------------------------------------------------
// xed_pkg
// Shared constants and name tables for the XML entity decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package xed_pkg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

    localparam int OUT_CAP = 16;
    localparam int OCNT_W  = $clog2(OUT_CAP + 1);
    localparam int NUM_NAMES = 5;

    localparam logic [20:0] CODE_MAX = 21'h10FFFF;
    localparam logic [20:0] SURR_LO  = 21'h00D800;
    localparam logic [20:0] SURR_HI  = 21'h00DFFF;

    typedef logic [20:0] code_t;

    // Name index: 0 amp, 1 lt, 2 gt, 3 quot, 4 apos
    function automatic logic [2:0] name_len(input int sel);
        logic [2:0] r;
        case (sel)
            0:       r = 3'd3;
            1, 2:    r = 3'd2;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] name_char(input int sel, input logic [1:0] k);
        logic [31:0] s;
        case (sel)
            0:       s = {8'h00, "p", "m", "a"};
            1:       s = {16'h0000, "t", "l"};
            2:       s = {16'h0000, "t", "g"};
            3:       s = {"t", "o", "u", "q"};
            default: s = {"s", "o", "p", "a"};
        endcase
        return s[k*8 +: 8];
    endfunction

    function automatic logic [7:0] name_out(input int sel);
        logic [7:0] r;
        case (sel)
            0:       r = CH_AMP;
            1:       r = CH_LT;
            2:       r = CH_GT;
            3:       r = CH_QUOT;
            default: r = CH_APOS;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/xed_utf8_enc.sv]
// ----------------------------------------------------------------------------
// xed_utf8_enc
// Picks one UTF-8 byte of a code point and gives the sequence length.
// ----------------------------------------------------------------------------
`default_nettype none
module xed_utf8_enc (
    input  wire xed_pkg::code_t code,
    input  wire logic [1:0]     idx,
    output logic [7:0]          enc_byte,
    output logic [2:0]          nbytes
);
    import xed_pkg::*;

    logic [7:0] b0, b1, b2, b3;

    always_comb begin
        b1 = 8'h80 | {2'b00, code[17:12]};
        b2 = 8'h80 | {2'b00, code[11:6]};
        b3 = 8'h80 | {2'b00, code[5:0]};
        if (code < 21'h80) begin
            nbytes = 3'd1;
            b0     = code[7:0];
        end else if (code < 21'h800) begin
            nbytes = 3'd2;
            b0     = 8'hC0 | {3'b000, code[10:6]};
        end else if (code < 21'h10000) begin
            nbytes = 3'd3;
            b0     = 8'hE0 | {4'h0, code[15:12]};
        end else begin
            nbytes = 3'd4;
            b0     = 8'hF0 | {5'b00000, code[20:18]};
        end
        case (idx)
            2'd0:    enc_byte = b0;
            2'd1:    enc_byte = (nbytes == 3'd2) ? b3 : ((nbytes == 3'd3) ? b2 : b1);
            2'd2:    enc_byte = (nbytes == 3'd3) ? b3 : b2;
            default: enc_byte = b3;
        endcase
    end
endmodule
`default_nettype wire

[sv/xml_entity_decoder.sv]
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Streaming XML entity decoder with UTF-8 output of numeric references.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time; s_tready is low until all results of
// that transfer have been handed to the output register. A plain byte passes
// through the run and finish states before the next input transfer is taken. A
// reference is held in a small window and scanned one byte per cycle by a shared
// digit multiply-accumulate and name compare; a closing ';' is then decoded and
// its result emitted byte by byte. A failed reference emits '&' and replays the
// window through the same sequencer, one byte per cycle while the output does
// not stall.
`default_nettype none
module xml_entity_decoder #(
    parameter int MAX_REF_SPAN = 12
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic [0:0] s_tuser,   // [0] byte_valid
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser,   // [0] byte_present, [1] text_done
    output logic            m_tlast    // last_of_run
);
    import xed_pkg::*;

    localparam int PTR_W = $clog2(MAX_REF_SPAN + 2);
    localparam int DEPTH = 1 << PTR_W;
    localparam logic [PTR_W-1:0] SPAN_LIM = PTR_W'(MAX_REF_SPAN - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_RES  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_UTF  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [7:0]       win_reg [DEPTH];
    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] rd_reg, rd_next, wr_reg, wr_next, head_reg, head_next;
    logic [PTR_W-1:0] idx_reg, idx_next, k_reg, k_next;
    logic             in_ref_reg, in_ref_next, end_reg, end_next;
    logic [NUM_NAMES-1:0] nm_reg, nm_next;
    logic             hash_reg, hash_next, hex_reg, hex_next;
    logic             dig_reg, dig_next, bad_reg, bad_next;
    code_t            code_reg, code_next;
    logic [1:0]       bi_reg, bi_next;
    logic [OCNT_W-1:0] cnt_reg, cnt_next;
    logic             hold_v_reg, hold_v_next;
    logic [7:0]       hold_reg, hold_next;
    logic             m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic [1:0]       m_user_reg, m_user_next;

    logic [PTR_W-1:0] raddr, span;
    logic [7:0]       cur;
    logic             out_free, push_req, push_take, stall;
    logic [7:0]       push_byte;
    logic [7:0]       enc_byte;
    logic [2:0]       nbytes;
    logic [3:0]       dval;
    logic             dok;
    logic [24:0]      mac;
    logic             name_hit, num_ok;
    logic [7:0]       name_byte;

    xed_utf8_enc u_enc (
        .code     (code_reg),
        .idx      (bi_reg),
        .enc_byte (enc_byte),
        .nbytes   (nbytes)
    );

    assign raddr    = (state_reg == S_RES) ? idx_reg : rd_reg;
    assign cur      = win_reg[raddr];
    assign span     = rd_reg - head_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // digit value and the shared multiply-accumulate
    always_comb begin
        dok  = 1'b0;
        dval = 4'd0;
        if (cur >= "0" && cur <= "9") begin
            dok = 1'b1; dval = 4'(cur - "0");
        end else if (hex_reg && cur >= "a" && cur <= "f") begin
            dok = 1'b1; dval = 4'(cur - "a" + 8'd10);
        end else if (hex_reg && cur >= "A" && cur <= "F") begin
            dok = 1'b1; dval = 4'(cur - "A" + 8'd10);
        end
        mac = (hex_reg ? {code_reg, 4'h0} : 25'(code_reg) * 25'd10) + 25'(dval);
    end

    always_comb begin
        name_hit  = 1'b0;
        name_byte = CH_AMP;
        for (int i = NUM_NAMES - 1; i >= 0; i--) begin
            if (nm_reg[i] && span == PTR_W'(name_len(i))) begin
                name_hit  = 1'b1;
                name_byte = name_out(i);
            end
        end
        num_ok = hash_reg && dig_reg && !bad_reg &&
                 !(code_reg >= SURR_LO && code_reg <= SURR_HI);
    end

    // what the sequencer wants to emit this cycle
    always_comb begin
        push_req  = 1'b0;
        push_byte = CH_AMP;
        case (state_reg)
            S_RUN: begin
                if (rd_reg != wr_reg) begin
                    if (!in_ref_reg) begin
                        push_req  = (cur != CH_AMP);
                        push_byte = cur;
                    end else if (cur != CH_SEMI && span >= SPAN_LIM) begin
                        push_req = 1'b1;
                    end
                end else if (end_reg && in_ref_reg) begin
                    push_req = 1'b1;
                end
            end
            S_DEC: begin
                push_req  = 1'b1;
                push_byte = name_hit ? name_byte : CH_AMP;
                if (!name_hit && num_ok) push_req = 1'b0;
            end
            S_UTF: begin
                push_req  = 1'b1;
                push_byte = enc_byte;
            end
            default: ;
        endcase
        push_take = push_req && (cnt_reg < OCNT_W'(OUT_CAP));
        stall     = push_take && hold_v_reg && !out_free;
    end

    always_comb begin
        state_next   = state_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        head_next    = head_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        in_ref_next  = in_ref_reg;
        end_next     = end_reg;
        nm_next      = nm_reg;
        hash_next    = hash_reg;
        hex_next     = hex_reg;
        dig_next     = dig_reg;
        bad_next     = bad_reg;
        code_next    = code_reg;
        bi_next      = bi_reg;
        cnt_next     = cnt_reg;
        hold_v_next  = hold_v_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        // lookahead by one byte so last_of_run is known when it leaves
        if (push_take && !stall) begin
            cnt_next    = cnt_reg + 1'b1;
            hold_v_next = 1'b1;
            hold_next   = push_byte;
            if (hold_v_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = hold_reg;
                m_last_next  = 1'b0;
                m_user_next  = 2'b01;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    end_next   = s_tlast;
                    state_next = S_RUN;
                    if (s_tuser[0]) wr_next = wr_reg + 1'b1;
                end
            end
            S_RUN: begin
                if (rd_reg != wr_reg) begin
                    if (!in_ref_reg) begin
                        if (cur == CH_AMP) begin
                            in_ref_next = 1'b1;
                            head_next   = rd_reg + 1'b1;
                            rd_next     = rd_reg + 1'b1;
                        end else if (!stall) begin
                            rd_next = rd_reg + 1'b1;
                        end
                    end else if (cur == CH_SEMI) begin
                        state_next = S_RES;
                        idx_next   = head_reg;
                        k_next     = '0;
                        nm_next    = '1;
                        hash_next  = 1'b0;
                        hex_next   = 1'b0;
                        dig_next   = 1'b0;
                        bad_next   = 1'b0;
                        code_next  = '0;
                    end else if (span < SPAN_LIM) begin
                        rd_next = rd_reg + 1'b1;
                    end else if (!stall) begin
                        in_ref_next = 1'b0;
                        rd_next     = head_reg;
                    end
                end else if (end_reg && in_ref_reg) begin
                    if (!stall) begin
                        in_ref_next = 1'b0;
                        rd_next     = head_reg;
                    end
                end else begin
                    state_next = S_FIN;
                end
            end
            S_RES: begin
                if (idx_reg == rd_reg) begin
                    state_next = S_DEC;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    k_next   = k_reg + 1'b1;
                    for (int i = 0; i < NUM_NAMES; i++) begin
                        if (k_reg >= PTR_W'(name_len(i)) || cur != name_char(i, k_reg[1:0]))
                            nm_next[i] = 1'b0;
                    end
                    if (k_reg == '0) begin
                        hash_next = (cur == CH_HASH);
                    end else if (k_reg == PTR_W'(1) && (cur == CH_LX || cur == CH_UX)) begin
                        hex_next = 1'b1;
                    end else if (!dok) begin
                        bad_next = 1'b1;
                    end else begin
                        dig_next = 1'b1;
                        if (!bad_reg) begin
                            if (mac > 25'(CODE_MAX)) bad_next = 1'b1;
                            else code_next = mac[20:0];
                        end
                    end
                end
            end
            S_DEC: begin
                if (!name_hit && num_ok) begin
                    state_next = S_UTF;
                    bi_next    = 2'd0;
                end else if (!stall) begin
                    in_ref_next = 1'b0;
                    rd_next     = name_hit ? rd_reg + 1'b1 : head_reg;
                    state_next  = S_RUN;
                end
            end
            S_UTF: begin
                if (!stall) begin
                    if ({1'b0, bi_reg} == nbytes - 3'd1) begin
                        in_ref_next = 1'b0;
                        rd_next     = rd_reg + 1'b1;
                        state_next  = S_RUN;
                    end else begin
                        bi_next = bi_reg + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (hold_v_reg || end_reg) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = hold_v_reg ? hold_reg : 8'h00;
                        m_last_next  = 1'b1;
                        m_user_next  = {end_reg, hold_v_reg};
                        hold_v_next  = 1'b0;
                        cnt_next     = '0;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_reg      <= '0;
            wr_reg      <= '0;
            head_reg    <= '0;
            in_ref_reg  <= 1'b0;
            end_reg     <= 1'b0;
            cnt_reg     <= '0;
            hold_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            head_reg    <= head_next;
            in_ref_reg  <= in_ref_next;
            end_reg     <= end_next;
            cnt_reg     <= cnt_next;
            hold_v_reg  <= hold_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        nm_reg     <= nm_next;
        hash_reg   <= hash_next;
        hex_reg    <= hex_next;
        dig_reg    <= dig_next;
        bad_reg    <= bad_next;
        code_reg   <= code_next;
        bi_reg     <= bi_next;
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    // window of held and replayed bytes
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid && s_tuser[0])
            win_reg[wr_reg] <= s_tdata;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;
endmodule
`default_nettype wire

[sv/xml_entity_decoder_checker.sv]
// ----------------------------------------------------------------------------
// xml_entity_decoder_checker
// Port-level checks on the entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module xml_entity_decoder_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("text_done without last_of_run");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tdata == 8'h00)
        else $error("malformed empty result");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an input transfer");
endmodule

bind xml_entity_decoder xml_entity_decoder_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
